// ===== hw/rtl/arw_pkg.sv =====
// shared types and constants for the anti-replay window block
// no dependencies; imported by the residue, window and top-level modules
package arw_pkg;

	localparam int SEQ_W              = 32;
	localparam int DEFAULT_WINDOW_BITS = 64;
	localparam int VERDICT_W          = 2;
	localparam int IN_TDATA_W         = 32;
	localparam int OUT_TDATA_W        = 8;

	// operation codes carried on the input tuser
	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_RECORD = 1'b1;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_OLD    = 2'd1,
		VERDICT_DUP    = 2'd2
	} verdict_t;

	// one request presented to the window state
	typedef struct packed {
		logic             fire;
		logic             op;
		logic [SEQ_W-1:0] seq;
	} arw_req_t;

endpackage

// ===== hw/rtl/anti_replay_window_core.sv =====
// anti-replay window, top level: input register, residue stage, window stage
// and result register; depends on arw_pkg, arw_residue and arw_window
//
// usage:
//   s_axis carries one request per sequence number: tdata is the 32-bit
//   number, tuser is the operation (0 check only, 1 check and record).
//   m_axis returns one verdict per request in the same order: tdata[1:0]
//   is 0 accepted, 1 too old, 2 duplicate; upper bits read zero.
//   an accepted request passes through the input register, the residue
//   register and the result register before m_axis tvalid rises; a stall
//   at m_axis can hold it in any of them.
//   one request per cycle is sustained while m_axis is ready; the window
//   state is read and updated together at the window stage, so
//   back-to-back numbers see each other's updates.
//   reset clears the top number and the seen bitmap, so number 0 is
//   accepted once after reset; all stages come up empty.
//   when m_axis stalls, the result register holds, the stages behind it
//   fill up and s_axis tready drops once all three are occupied.
module anti_replay_window_core #(
	parameter int WINDOW_BITS = arw_pkg::DEFAULT_WINDOW_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [arw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [31:0] seq_number
	input  logic [0:0]                       s_axis_tuser,  // [0] operation
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [arw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [1:0] verdict, [7:2] zero
);
	import arw_pkg::*;

	localparam int POS_W = $clog2(WINDOW_BITS);

	logic             valid_s1;
	logic             op_s1;
	logic [SEQ_W-1:0] seq_s1;

	logic             valid_s2;
	logic             op_s2;
	logic [SEQ_W-1:0] seq_s2;
	logic [POS_W-1:0] pos_s2;

	logic             out_valid_q;
	verdict_t         verdict_q;

	logic             s_acc;
	logic             out_ready;
	logic             s2_ready;
	logic             adv1;
	logic             adv2;
	logic [POS_W-1:0] pos_s1;
	arw_req_t         req;
	verdict_t         verdict;

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign adv2          = valid_s2 && out_ready;
	assign s2_ready      = !valid_s2 || out_ready;
	assign adv1          = valid_s1 && s2_ready;
	assign s_axis_tready = !valid_s1 || s2_ready;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	arw_residue #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_residue (
		.seq(seq_s1),
		.pos(pos_s1)
	);

	assign req.fire = adv2;
	assign req.op   = op_s2;
	assign req.seq  = seq_s2;

	arw_window #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pos    (pos_s2),
		.verdict(verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_acc)
				valid_s1 <= 1'b1;
			else if (adv1)
				valid_s1 <= 1'b0;

			if (adv1)
				valid_s2 <= 1'b1;
			else if (adv2)
				valid_s2 <= 1'b0;

			if (adv2)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1  <= s_axis_tuser[0];
			seq_s1 <= s_axis_tdata[SEQ_W-1:0];
		end
		if (adv1) begin
			op_s2  <= op_s1;
			seq_s2 <= seq_s1;
			pos_s2 <= pos_s1;
		end
		if (adv2)
			verdict_q <= verdict;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W-VERDICT_W)'(0), verdict_q};

	// a request leaving the window stage always lands in the result register
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 |=> out_valid_q)
		else $error("window stage advanced without filling result register");

	// input back-pressure only when every stage is occupied
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && out_valid_q && !m_axis_tready))
		else $error("input stalled while pipeline has room");

	// code three is never produced
	a_no_code3: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
		else $error("undefined verdict code on output");

endmodule

// ===== hw/rtl/arw_residue.sv =====
// sequence number modulo window size, by byte residue tables and a fold table
// depends on arw_pkg; tables are built at elaboration from WINDOW_BITS
module arw_residue #(
	parameter int WINDOW_BITS = arw_pkg::DEFAULT_WINDOW_BITS
) (
	input  logic [arw_pkg::SEQ_W-1:0]       seq,
	output logic [$clog2(WINDOW_BITS)-1:0]  pos
);
	import arw_pkg::*;

	localparam int POS_W = $clog2(WINDOW_BITS);

	// entry b holds (b * 2^shift) mod WINDOW_BITS
	function automatic logic [256*POS_W-1:0] byte_table(input int shift);
		logic [256*POS_W-1:0] t;
		int c;
		int v;
		t = '0;
		c = 1;
		for (int k = 0; k < shift; k++) begin
			c = c * 2;
			if (c >= WINDOW_BITS) c = c - WINDOW_BITS;
		end
		v = 0;
		for (int b = 0; b < 256; b++) begin
			t[b*POS_W +: POS_W] = POS_W'(v);
			v = v + c;
			if (v >= WINDOW_BITS) v = v - WINDOW_BITS;
		end
		return t;
	endfunction

	localparam logic [256*POS_W-1:0] TAB_B0 = byte_table(0);
	localparam logic [256*POS_W-1:0] TAB_B1 = byte_table(8);
	localparam logic [256*POS_W-1:0] TAB_B2 = byte_table(16);
	localparam logic [256*POS_W-1:0] TAB_B3 = byte_table(24);
	// fold table is plain reduction of an 8-bit sum
	localparam logic [256*POS_W-1:0] TAB_FOLD = byte_table(0);

	logic [POS_W-1:0] r0, r1, r2, r3;
	logic [7:0]       rsum;

	always_comb begin
		r0   = TAB_B0[seq[7:0]*POS_W +: POS_W];
		r1   = TAB_B1[seq[15:8]*POS_W +: POS_W];
		r2   = TAB_B2[seq[23:16]*POS_W +: POS_W];
		r3   = TAB_B3[seq[31:24]*POS_W +: POS_W];
		// four residues below 64 each, sum stays below 256
		rsum = 8'(r0) + 8'(r1) + 8'(r2) + 8'(r3);
		pos  = TAB_FOLD[rsum*POS_W +: POS_W];
	end

endmodule

// ===== hw/rtl/arw_window.sv =====
// window state: top sequence number, its bit position and the seen bitmap
// depends on arw_pkg; classifies one request and records it when accepted and the operation is record
module arw_window #(
	parameter int WINDOW_BITS = arw_pkg::DEFAULT_WINDOW_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  arw_pkg::arw_req_t               req,
	input  logic [$clog2(WINDOW_BITS)-1:0]  pos,
	output arw_pkg::verdict_t               verdict
);
	import arw_pkg::*;

	localparam int POS_W = $clog2(WINDOW_BITS);
	localparam logic [POS_W:0]   W_N   = (POS_W+1)'(WINDOW_BITS);
	localparam logic [SEQ_W-1:0] W_SEQ = SEQ_W'(WINDOW_BITS);

	logic [SEQ_W-1:0]       top_q;
	logic [POS_W-1:0]       top_pos_q;
	logic [WINDOW_BITS-1:0] bitmap_q;

	logic                   above;
	logic                   too_old;
	logic                   dup;
	logic                   do_record;
	logic [SEQ_W-1:0]       gap;
	logic                   near;
	logic [WINDOW_BITS-1:0] keep;
	logic [WINDOW_BITS-1:0] bitmap_next;
	logic [POS_W:0]         span;

	always_comb begin
		above   = req.seq > top_q;
		too_old = !above && ((req.seq + W_SEQ) <= top_q);
		dup     = bitmap_q[pos];
		if (above)
			verdict = VERDICT_ACCEPT;
		else if (too_old)
			verdict = VERDICT_OLD;
		else if (dup)
			verdict = VERDICT_DUP;
		else
			verdict = VERDICT_ACCEPT;

		do_record = req.fire && (req.op == OP_RECORD) && (verdict == VERDICT_ACCEPT);
		gap       = req.seq - top_q;
		near      = gap < W_SEQ;

		// clear positions strictly between the old top and the new number
		for (int i = 0; i < WINDOW_BITS; i++) begin
			if ((POS_W+1)'(i) >= {1'b0, top_pos_q})
				span = (POS_W+1)'(i) - {1'b0, top_pos_q};
			else
				span = (POS_W+1)'(i) + W_N - {1'b0, top_pos_q};
			keep[i] = !((span != '0) && (span < gap[POS_W:0]));
		end

		bitmap_next = bitmap_q;
		if (above) begin
			if (near)
				bitmap_next = bitmap_q & keep;
			else
				bitmap_next = '0;
		end
		bitmap_next[pos] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			top_pos_q <= '0;
			bitmap_q  <= '0;
		end else if (do_record) begin
			bitmap_q <= bitmap_next;
			if (above) begin
				top_q     <= req.seq;
				top_pos_q <= pos;
			end
		end
	end

endmodule
